// ----- rtl/tcw_pkg.sv -----
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, operation codes and control/status types for the text
// console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // field widths
    localparam int FUNC_W  = 2;
    localparam int CHAR_W  = 8;
    localparam int IDX_W   = 11;
    localparam int COL_W   = 7;
    localparam int ROW_W   = 5;
    localparam int CELL_W  = 16;
    localparam int ATTR_W  = 8;

    // screen address and sweep counter widths
    localparam int ADDR_W  = $clog2(CELLS);
    localparam int CNT_W   = $clog2(CELLS + 1);

    // character codes and cell values
    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'd32;
    localparam logic [ATTR_W-1:0] COLOR_RESET  = 8'd15;
    localparam logic [CELL_W-1:0] BLANK_RESET  = {COLOR_RESET, SPACE_CODE};

    // operation codes
    typedef logic [FUNC_W-1:0] func_t;
    localparam func_t FUNC_PUT   = 2'd0;
    localparam func_t FUNC_ERASE = 2'd1;
    localparam func_t FUNC_CLEAR = 2'd2;
    localparam func_t FUNC_READ  = 2'd3;

    // commands from the controller to the datapath
    typedef struct packed {
        logic capture;       // take the input word into the item registers
        logic exec;          // update cursor and do the single-cell access
        logic sweep_init;    // reset fill with the power-on blank
        logic sweep_fill;    // clear-screen fill with the current color
        logic sweep_scroll;  // scroll copy followed by bottom-row blanking
        logic sweep_clr;     // return the sweep counter to zero
        logic out_load;      // load the output word register
    } tcw_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        func_t func;
        logic  need_scroll;
        logic  fill_last;
        logic  scroll_last;
        logic  out_free;
    } tcw_status_t;

endpackage

// ----- rtl/tcw_ctrl.sv -----
// ----------------------------------------------------------------------------
// tcw_ctrl
// Controller state machine: sequences the power-on fill, single-cell
// operations, clear and scroll sweeps, and the output hand-off.
// ----------------------------------------------------------------------------
module tcw_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tcw_pkg::tcw_status_t status,
    output tcw_pkg::tcw_cmd_t    cmd
);
    import tcw_pkg::*;

    localparam logic [2:0] ST_INIT   = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_EXEC   = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_FILL   = 3'd4;
    localparam logic [2:0] ST_SCROLL = 3'd5;
    localparam logic [2:0] ST_DONE   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb
    begin
        state_next       = state_reg;
        cmd              = '0;
        cmd.capture      = in_ready & in_valid;
        case (state_reg)
            ST_INIT:
            begin
                cmd.sweep_init = 1'b1;
                if (status.fill_last)
                begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.func == FUNC_CLEAR)
                begin
                    state_next = ST_FILL;
                end
                else if (status.need_scroll)
                begin
                    state_next = ST_SCROLL;
                end
                else if (status.func == FUNC_READ)
                begin
                    state_next = ST_READ;
                end
                else if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FILL:
            begin
                cmd.sweep_fill = 1'b1;
                if (status.fill_last)
                begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_SCROLL:
            begin
                cmd.sweep_scroll = 1'b1;
                if (status.scroll_last)
                begin
                    cmd.sweep_clr = 1'b1;
                    state_next    = ST_DONE;
                end
            end
            ST_READ, ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

endmodule

// ----- rtl/tcw_datapath.sv -----
// ----------------------------------------------------------------------------
// tcw_datapath
// Screen memory, cursor and color registers, sweep counter and the output
// word register of the text console writer.
// ----------------------------------------------------------------------------
module tcw_datapath
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  tcw_pkg::tcw_cmd_t                cmd,
    output tcw_pkg::tcw_status_t             status,
    input  tcw_pkg::func_t                   in_func,
    input  logic [tcw_pkg::CHAR_W-1:0]       in_char,
    input  logic [tcw_pkg::IDX_W-1:0]        in_idx,
    input  logic                             cfg_wr_en,
    input  logic [tcw_pkg::ATTR_W-1:0]       cfg_wr_data,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [tcw_pkg::COL_W-1:0]        out_col,
    output logic [tcw_pkg::ROW_W-1:0]        out_row,
    output logic [tcw_pkg::CELL_W-1:0]       out_cell,
    output logic                             out_scrolled
);
    import tcw_pkg::*;

    // screen storage
    logic [CELL_W-1:0] screen_mem [CELLS];
    logic [CELL_W-1:0] rd_data_reg;

    // item registers
    func_t             func_reg;
    logic [CHAR_W-1:0] char_reg;
    logic [IDX_W-1:0]  idx_reg;

    // cursor, color and per-item flags
    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;
    logic [ATTR_W-1:0] color_reg;
    logic              scrolled_reg;
    logic              scrolled_next;
    logic              in_range_reg;

    // sweep counter
    logic [CNT_W-1:0]  sweep_reg;
    logic [CNT_W-1:0]  sweep_next;
    logic [CNT_W-1:0]  sweep_dec;

    // output word register
    logic              out_valid_reg;
    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [CELL_W-1:0] out_cell_reg;
    logic              out_scrolled_reg;

    // memory port signals
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CELL_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    logic [CELL_W-1:0] blank_cell;
    logic [ADDR_W-1:0] pos_cur;
    logic              at_origin;
    logic              at_last_col;
    logic              at_last_row;
    logic              idx_in_range;
    logic              copy_phase;
    logic              put_char;
    logic              do_erase;

    assign blank_cell   = {color_reg, SPACE_CODE};
    assign pos_cur      = ADDR_W'(row_reg * COLUMNS) + ADDR_W'(col_reg);
    assign at_origin    = (col_reg == '0) && (row_reg == '0);
    assign at_last_col  = (col_reg == COL_W'(COLUMNS - 1));
    assign at_last_row  = (row_reg == ROW_W'(ROWS - 1));
    assign idx_in_range = (idx_reg < IDX_W'(CELLS));
    assign sweep_dec    = sweep_reg - 1'b1;
    assign copy_phase   = (sweep_reg < CNT_W'(CELLS - COLUMNS));
    assign put_char     = (func_reg == FUNC_PUT) && (char_reg != NEWLINE_CODE);
    assign do_erase     = (func_reg == FUNC_ERASE) && !at_origin;

    // status to the controller
    assign status.func        = func_reg;
    assign status.need_scroll = (func_reg == FUNC_PUT) && at_last_row &&
                                ((char_reg == NEWLINE_CODE) || at_last_col);
    assign status.fill_last   = (sweep_reg == CNT_W'(CELLS - 1));
    assign status.scroll_last = (sweep_reg == CNT_W'(CELLS));
    assign status.out_free    = !out_valid_reg || out_ready;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg <= in_func;
            char_reg <= in_char;
            idx_reg  <= in_idx;
        end
    end

    // cursor update for one operation
    always_comb
    begin
        col_next      = col_reg;
        row_next      = row_reg;
        scrolled_next = scrolled_reg;
        if (cmd.exec)
        begin
            scrolled_next = status.need_scroll;
            case (func_reg)
                FUNC_PUT:
                begin
                    if ((char_reg == NEWLINE_CODE) || at_last_col)
                    begin
                        col_next = '0;
                        if (!at_last_row)
                        begin
                            row_next = row_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                FUNC_ERASE:
                begin
                    if (!at_origin)
                    begin
                        if (col_reg != '0)
                        begin
                            col_next = col_reg - 1'b1;
                        end
                        else
                        begin
                            col_next = COL_W'(COLUMNS - 1);
                            row_next = row_reg - 1'b1;
                        end
                    end
                end
                FUNC_CLEAR:
                begin
                    col_next = '0;
                    row_next = '0;
                end
                default:
                begin
                    col_next = col_reg;
                end
            endcase
        end
    end

    // cursor, color and flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            color_reg    <= COLOR_RESET;
            scrolled_reg <= 1'b0;
            in_range_reg <= 1'b0;
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            scrolled_reg <= scrolled_next;
            if (cfg_wr_en)
            begin
                color_reg <= cfg_wr_data;
            end
            if (cmd.exec)
            begin
                in_range_reg <= idx_in_range;
            end
        end
    end

    // sweep counter
    always_comb
    begin
        sweep_next = sweep_reg;
        if (cmd.sweep_clr)
        begin
            sweep_next = '0;
        end
        else if (cmd.sweep_init || cmd.sweep_fill || cmd.sweep_scroll)
        begin
            sweep_next = sweep_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sweep_reg <= '0;
        end
        else
        begin
            sweep_reg <= sweep_next;
        end
    end

    // memory port selection
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pos_cur;
        wr_data = blank_cell;
        rd_en   = 1'b0;
        rd_addr = idx_reg[ADDR_W-1:0];
        if (cmd.sweep_init)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_reg[ADDR_W-1:0];
            wr_data = BLANK_RESET;
        end
        else if (cmd.sweep_fill)
        begin
            wr_en   = 1'b1;
            wr_addr = sweep_reg[ADDR_W-1:0];
            wr_data = blank_cell;
        end
        else if (cmd.sweep_scroll)
        begin
            // read one row below, write the word read last cycle one cell back
            rd_en   = copy_phase;
            rd_addr = ADDR_W'(sweep_reg + CNT_W'(COLUMNS));
            wr_en   = (sweep_reg != '0);
            wr_addr = sweep_dec[ADDR_W-1:0];
            wr_data = (sweep_reg <= CNT_W'(CELLS - COLUMNS)) ? rd_data_reg : blank_cell;
        end
        else if (cmd.exec)
        begin
            if (put_char)
            begin
                wr_en   = 1'b1;
                wr_addr = pos_cur;
                wr_data = {color_reg, char_reg};
            end
            else if (do_erase)
            begin
                wr_en   = 1'b1;
                wr_addr = pos_cur - 1'b1;
                wr_data = blank_cell;
            end
            rd_en = (func_reg == FUNC_READ) && idx_in_range;
        end
    end

    // screen memory, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            screen_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= screen_mem[rd_addr];
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_col_reg      <= col_next;
            out_row_reg      <= row_next;
            out_scrolled_reg <= scrolled_next;
            out_cell_reg     <= ((func_reg == FUNC_READ) && in_range_reg) ? rd_data_reg : '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_col      = out_col_reg;
    assign out_row      = out_row_reg;
    assign out_cell     = out_cell_reg;
    assign out_scrolled = out_scrolled_reg;

endmodule

// ----- rtl/text_console_writer.sv -----
// ----------------------------------------------------------------------------
// text_console_writer
// Text-mode console engine: an 80x25 screen of 16-bit cells with a cursor,
// driven by put, erase-back, clear and read-cell operations.
// ----------------------------------------------------------------------------
// One operation is taken at a time and returns one result word. Put and
// erase-back go from acceptance to an execute state that loads the result
// word if the output register is free, else a done state waits for it; a
// read also passes a read state, whether or not the address lies on the
// screen, as every read waits for the registered read port of the screen
// memory. Clear writes one cell per cycle over the whole screen. A put
// that wraps past the bottom row scrolls: the memory copies each cell one
// row up through its single read and single write port, one cell per cycle,
// then blanks the bottom row. After reset the block fills the screen with
// blank cells (color 15, space), one cell per cycle, and holds s_tready low
// until that pass is done; color writes are taken at any time. The result
// word waits in an output register, so the next operation is accepted while
// it is unread.
module text_console_writer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code[7:0], cell_index[18:8]
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // cursor_col[6:0], cursor_row[11:7],
                                   // cell_data[27:12], scrolled[28]
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data
);
    import tcw_pkg::*;

    tcw_cmd_t          cmd;
    tcw_status_t       status;
    logic [COL_W-1:0]  out_col;
    logic [ROW_W-1:0]  out_row;
    logic [CELL_W-1:0] out_cell;
    logic              out_scrolled;

    // controller
    tcw_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath with screen memory
    tcw_datapath u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .in_func      (s_tuser),
        .in_char      (s_tdata[7:0]),
        .in_idx       (s_tdata[18:8]),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_col      (out_col),
        .out_row      (out_row),
        .out_cell     (out_cell),
        .out_scrolled (out_scrolled)
    );

    // pack the result word
    assign m_tdata = {3'b000, out_scrolled, out_cell, out_row, out_col};

endmodule

// ----- verif/text_console_writer_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// text_console_writer_tb
// Self-checking bench for the text console writer. A cycle-free model of the
// screen, cursor and color register predicts the status word of every
// accepted operation. Directed corner cases come first, then a scroll walk, a
// receiver hold-off and random text sessions under several colors.
// ----------------------------------------------------------------------------
module text_console_writer_tb;

    import tcw_pkg::*;

    localparam int IDX_MAX = (1 << IDX_W) - 1;

    // status word fields, lowest field in the lowest bits
    typedef struct packed {
        logic              scrolled;
        logic [CELL_W-1:0] cell_data;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
    } console_status_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;     // char_code[7:0], cell_index[18:8]
    logic [1:0]  s_tuser = '0;     // func[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;          // cursor_col[6:0], cursor_row[11:7],
                                   // cell_data[27:12], scrolled[28]
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = '0;

    // screen model and cursor
    logic [CELL_W-1:0] screen_model [0:CELLS-1];
    int unsigned       cur_col;
    int unsigned       cur_row;
    logic [ATTR_W-1:0] attr_byte;

    console_status_t pending_status_q [$];
    int              mismatch_count = 0;
    int              burst_left = 0;
    int              hold_requests = 0;
    int              hold_served = 0;
    int              hold_left = 0;
    int              stall_mode = 0;
    int              stall_phase = 0;
    int unsigned     rx_tick = 0;

    text_console_writer u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // screen model
    // ------------------------------------------------------------------------
    function automatic void blank_screen(input logic [CELL_W-1:0] fill_word);
        for (int i = 0; i < CELLS; i++)
            screen_model[i] = fill_word;
    endfunction

    // cursor to the start of the next row, scrolling off the bottom
    function automatic logic advance_row();
        cur_col = 0;
        cur_row++;
        if (cur_row < ROWS)
            return 1'b0;
        for (int i = 0; i < CELLS - COLUMNS; i++)
            screen_model[i] = screen_model[i + COLUMNS];
        for (int i = CELLS - COLUMNS; i < CELLS; i++)
            screen_model[i] = {attr_byte, SPACE_CODE};
        cur_row = ROWS - 1;
        return 1'b1;
    endfunction

    function automatic console_status_t apply_console_op(input func_t op,
                                                         input logic [7:0] ch,
                                                         input logic [10:0] idx);
        console_status_t res;
        res = '0;
        case (op)
            FUNC_PUT:
            begin
                if (ch == NEWLINE_CODE)
                    res.scrolled = advance_row();
                else
                begin
                    screen_model[cur_row * COLUMNS + cur_col] = {attr_byte, ch};
                    cur_col++;
                    if (cur_col >= COLUMNS)
                        res.scrolled = advance_row();
                end
            end
            FUNC_ERASE:
            begin
                // nothing moves at the top-left cell
                if (cur_col != 0 || cur_row != 0)
                begin
                    if (cur_col != 0)
                        cur_col--;
                    else
                    begin
                        cur_col = COLUMNS - 1;
                        cur_row--;
                    end
                    screen_model[cur_row * COLUMNS + cur_col] = {attr_byte, SPACE_CODE};
                end
            end
            FUNC_CLEAR:
            begin
                blank_screen({attr_byte, SPACE_CODE});
                cur_col = 0;
                cur_row = 0;
            end
            default:
            begin
                // out-of-range reads return zero
                if (idx < CELLS)
                    res.cell_data = screen_model[idx];
            end
        endcase
        res.col = cur_col[COL_W-1:0];
        res.row = cur_row[ROW_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // sender: bursts of words with random gaps
    // ------------------------------------------------------------------------
    task automatic send_op(input func_t op, input logic [7:0] ch, input logic [10:0] idx);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            case ($urandom_range(0, 7))
                0, 1:    gap = 0;
                2:       gap = $urandom_range(20, 60);
                default: gap = $urandom_range(1, 8);
            endcase
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {5'd0, idx, ch};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_status_q.push_back(apply_console_op(op, ch, idx));
    endtask

    task automatic put_char(input logic [7:0] ch);
        send_op(FUNC_PUT, ch, 11'($urandom_range(0, IDX_MAX)));
    endtask

    task automatic read_cell(input int unsigned idx);
        send_op(FUNC_READ, 8'($urandom), 11'(idx));
    endtask

    // stop sending and wait for every status word and a ready block
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_status_q.size() != 0 || !s_tready)
            @(posedge clk);
    endtask

    task automatic set_color(input logic [ATTR_W-1:0] value);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        attr_byte = value;
    endtask

    // mostly text runs and newlines, with edits, reads and rare clears
    task automatic send_random_op();
        int          pick;
        int unsigned pos;
        func_t       op;
        logic [7:0]  ch;
        logic [10:0] idx;
        pick = $urandom_range(0, 999);
        op   = FUNC_PUT;
        ch   = 8'($urandom);
        idx  = 11'($urandom_range(0, IDX_MAX));
        if (pick < 4)
            op = FUNC_CLEAR;
        else if (pick < 100)
            op = FUNC_ERASE;
        else if (pick < 230)
        begin
            op = FUNC_READ;
            case ($urandom_range(0, 9))
                0: idx = 11'($urandom_range(CELLS, IDX_MAX));
                1, 2, 3:
                begin
                    pos = cur_row * COLUMNS + cur_col;
                    idx = 11'((pos + CELLS - $urandom_range(1, 2 * COLUMNS)) % CELLS);
                end
                default: idx = 11'($urandom_range(0, CELLS - 1));
            endcase
        end
        else if (pick < 350)
            ch = NEWLINE_CODE;
        else if (pick < 700)
            ch = 8'($urandom_range(32, 126));
        send_op(op, ch, idx);
    endtask

    // ------------------------------------------------------------------------
    // receiver: changing stall pattern plus requested long hold-offs
    // ------------------------------------------------------------------------
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready    <= 1'b0;
            hold_served <= 0;
            hold_left   <= 0;
            stall_mode  <= 0;
            stall_phase <= 0;
            rx_tick     <= 0;
        end
        else
        begin
            rx_tick <= rx_tick + 1;
            if (hold_requests != hold_served)
            begin
                hold_served <= hold_requests;
                hold_left   <= 400;
                m_tready    <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end
            else
            begin
                if (stall_phase == 0)
                begin
                    stall_mode  <= $urandom_range(0, 3);
                    stall_phase <= $urandom_range(16, 128);
                end
                else
                    stall_phase <= stall_phase - 1;
                case (stall_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom);
                    2:       m_tready <= (rx_tick[2:0] == 3'd0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // status word checker
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : check_status
        console_status_t want;
        console_status_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = console_status_t'(m_tdata[28:0]);
            if (pending_status_q.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: status word %h with nothing pending", $realtime, m_tdata);
            end
            else
            begin
                want = pending_status_q.pop_front();
                if (got.col != want.col || got.row != want.row
                    || got.cell_data != want.cell_data || got.scrolled != want.scrolled)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: col %0d/%0d row %0d/%0d cell %h/%h scrolled %b/%b",
                                 $realtime, want.col, got.col, want.row, got.row,
                                 want.cell_data, got.cell_data, want.scrolled, got.scrolled);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------
    task automatic test_corner_cases();
        send_op(FUNC_ERASE, 8'h00, 11'h000);     // erase at top-left does nothing
        read_cell(0);                            // power-on blank
        read_cell(CELLS - 1);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(8'hAA);
        put_char(8'h55);
        read_cell(0);
        read_cell(3);
        put_char(NEWLINE_CODE);                  // to column 0 of row 1
        send_op(FUNC_ERASE, 8'hFF, 11'h7FF);     // wraps to the last column of row 0
        read_cell(COLUMNS - 1);
        put_char(8'h41);                         // last column, wraps to row 1
        read_cell(COLUMNS - 1);
        read_cell(CELLS);                        // just past the screen
        read_cell(IDX_MAX);
        send_op(FUNC_CLEAR, 8'h7F, 11'h400);
        read_cell(1);
        read_cell(1024);
        send_op(FUNC_ERASE, 8'h00, 11'h3FF);
    endtask

    task automatic test_scroll();
        send_op(FUNC_CLEAR, 8'h00, 11'h000);
        repeat (ROWS - 1) put_char(NEWLINE_CODE);
        repeat (5) put_char(8'($urandom_range(33, 126)));
        put_char(NEWLINE_CODE);                  // newline on the bottom row scrolls
        read_cell((ROWS - 2) * COLUMNS + 2);
        read_cell((ROWS - 1) * COLUMNS);
        repeat (COLUMNS + 3) put_char(8'($urandom_range(33, 126)));
        repeat (5) send_op(FUNC_ERASE, 8'($urandom), 11'($urandom_range(0, IDX_MAX)));
        read_cell((ROWS - 1) * COLUMNS - 1);
        read_cell((ROWS - 1) * COLUMNS + 1);
        read_cell(CELLS - 1);
        put_char(NEWLINE_CODE);
        read_cell((ROWS - 2) * COLUMNS);
    endtask

    // receiver holds off while the sender keeps offering words
    task automatic test_backpressure();
        wait_idle();
        hold_requests <= hold_requests + 1;
        repeat (40) send_random_op();
        wait_idle();
        repeat (20) send_random_op();
    endtask

    task automatic test_random();
        logic [ATTR_W-1:0] colors [5];
        colors = '{8'h00, 8'($urandom), 8'hFF, 8'($urandom), COLOR_RESET};
        foreach (colors[k])
        begin
            set_color(colors[k]);
            repeat (215) send_random_op();
        end
    endtask

    initial
    begin
        attr_byte = COLOR_RESET;
        cur_col = 0;
        cur_row = 0;
        blank_screen(BLANK_RESET);
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        wait_idle();

        test_corner_cases();
        set_color(8'hFF);
        test_scroll();
        test_backpressure();
        test_random();

        wait_idle();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // run limit
    initial
    begin
        #100_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- text_console_writer.f -----
rtl/tcw_pkg.sv
rtl/tcw_ctrl.sv
rtl/tcw_datapath.sv
rtl/text_console_writer.sv
verif/text_console_writer_tb.sv
